// ===== hdl/mtcq_pkg.sv =====
// Shared types and codes for the multi-timer callout queue.
package mtcq_pkg;

    localparam int NUM_TIMERS_DEF = 16;

    localparam int PERIOD_W  = 31;
    localparam int TICK_W    = 48;
    localparam int HANDLE_W  = 4;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;

    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FAIL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FIRED = 2'd2;

    typedef struct packed {
        logic                periodic;
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] remaining;
    } slot_entry_t;

endpackage

// ===== hdl/multi_timer_callout_queue_core.sv =====
// A bank of countdown timers with a per-slot memory scanned on every tick.
//
// A start or cancel transaction first updates the slot and then hands the
// result to the output register. A tick walks the slots one at a time
// through the single port of the slot memory: an idle slot is only passed
// over, and an active slot is read, then decremented and written back.
// When any timer expired, the final fired result is handed out after the
// walk. A stalled output holds any hand-out, and holds the walk when an expiry waits.
// Fired timers come out in ascending slot order, and the final one of a
// tick carries last. The input is stalled while a transaction is in
// progress; the output register lets a new input be taken while the
// previous result still waits.
module multi_timer_callout_queue_core #(
    parameter int NUM_TIMERS = mtcq_pkg::NUM_TIMERS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mtcq_pkg::KIND_W-1:0]   kind,
    input  logic [mtcq_pkg::PERIOD_W-1:0] period_ms,
    input  logic                          periodic,
    input  logic [mtcq_pkg::HANDLE_W-1:0] target_handle,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mtcq_pkg::STATUS_W-1:0] status,
    output logic [mtcq_pkg::HANDLE_W-1:0] handle,
    output logic                          last,
    output logic [mtcq_pkg::TICK_W-1:0]   elapsed_ticks
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RD    = 2'd1;
    localparam logic [1:0] S_WR    = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [NUM_TIMERS-1:0] active_reg, active_next;
    logic [mtcq_pkg::TICK_W-1:0] tick_reg, tick_next;

    logic pend_valid_reg, pend_valid_next;
    logic [mtcq_pkg::STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic [mtcq_pkg::HANDLE_W-1:0] pend_handle_reg, pend_handle_next;

    logic out_valid_reg;
    logic [mtcq_pkg::STATUS_W-1:0] status_reg;
    logic [mtcq_pkg::HANDLE_W-1:0] handle_reg;
    logic last_reg;
    logic [mtcq_pkg::TICK_W-1:0] elapsed_reg;

    mtcq_pkg::slot_entry_t slot_mem [NUM_TIMERS];
    mtcq_pkg::slot_entry_t rd_data_reg;
    mtcq_pkg::slot_entry_t mem_wdata;
    logic mem_we;
    logic [IW-1:0] mem_waddr;
    logic rd_en;

    logic push;
    logic push_last;
    logic out_free;

    logic [NUM_TIMERS-1:0] free_vec;
    logic [NUM_TIMERS-1:0] lowest_free;
    logic any_free;
    logic [IW-1:0] free_idx;

    logic [6:0] tgt_wide;
    logic tgt_in_range;
    logic [IW-1:0] tgt_idx;

    logic [mtcq_pkg::PERIOD_W-1:0] rem_dec;
    logic fire;
    logic last_slot;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    // Isolate the lowest clear active bit with the two's complement trick.
    assign free_vec    = ~active_reg;
    assign lowest_free = free_vec & (~free_vec + NUM_TIMERS'(1));
    assign any_free    = |free_vec;

    always_comb
    begin
        free_idx = '0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            if (lowest_free[i])
            begin
                free_idx = free_idx | IW'(i);
            end
        end
    end

    assign tgt_wide     = 7'(target_handle);
    assign tgt_in_range = tgt_wide < 7'(NUM_TIMERS);
    assign tgt_idx      = tgt_wide[IW-1:0];

    assign rem_dec   = rd_data_reg.remaining - 1'b1;
    assign fire      = (rem_dec == '0);
    assign last_slot = (idx_reg == IW'(NUM_TIMERS - 1));

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        active_next      = active_reg;
        tick_next        = tick_reg;
        pend_valid_next  = pend_valid_reg;
        pend_status_next = pend_status_reg;
        pend_handle_next = pend_handle_reg;
        push             = 1'b0;
        push_last        = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = idx_reg;
        mem_wdata        = rd_data_reg;
        rd_en            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (kind)
                        mtcq_pkg::KIND_TICK:
                        begin
                            tick_next       = tick_reg + 1'b1;
                            idx_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_RD;
                        end
                        mtcq_pkg::KIND_START:
                        begin
                            pend_valid_next = 1'b1;
                            state_next      = S_FLUSH;
                            if ((period_ms != '0) && any_free)
                            begin
                                active_next[free_idx] = 1'b1;
                                mem_we              = 1'b1;
                                mem_waddr           = free_idx;
                                mem_wdata.periodic  = periodic;
                                mem_wdata.period    = period_ms;
                                mem_wdata.remaining = period_ms;
                                pend_status_next    = mtcq_pkg::STATUS_OK;
                                pend_handle_next    = 4'(free_idx);
                            end
                            else
                            begin
                                pend_status_next = mtcq_pkg::STATUS_FAIL;
                                pend_handle_next = '0;
                            end
                        end
                        mtcq_pkg::KIND_CANCEL:
                        begin
                            pend_valid_next  = 1'b1;
                            pend_handle_next = target_handle;
                            state_next       = S_FLUSH;
                            if (tgt_in_range && active_reg[tgt_idx])
                            begin
                                active_next[tgt_idx] = 1'b0;
                                pend_status_next     = mtcq_pkg::STATUS_OK;
                            end
                            else
                            begin
                                pend_status_next = mtcq_pkg::STATUS_FAIL;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_RD:
            begin
                if (active_reg[idx_reg])
                begin
                    rd_en      = 1'b1;
                    state_next = S_WR;
                end
                else if (last_slot)
                begin
                    state_next = pend_valid_reg ? S_FLUSH : S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_WR:
            begin
                // A second expiry must wait until the earlier one has moved out.
                if (!(fire && pend_valid_reg && !out_free))
                begin
                    mem_we = 1'b1;
                    if (fire)
                    begin
                        if (rd_data_reg.periodic)
                        begin
                            mem_wdata.remaining = rd_data_reg.period;
                        end
                        else
                        begin
                            mem_wdata.remaining = rem_dec;
                            active_next[idx_reg] = 1'b0;
                        end
                        push             = pend_valid_reg;
                        pend_valid_next  = 1'b1;
                        pend_status_next = mtcq_pkg::STATUS_FIRED;
                        pend_handle_next = 4'(idx_reg);
                    end
                    else
                    begin
                        mem_wdata.remaining = rem_dec;
                    end

                    if (last_slot)
                    begin
                        state_next = (fire || pend_valid_reg) ? S_FLUSH : S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end

            S_FLUSH:
            begin
                if (out_free)
                begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            active_reg     <= '0;
            tick_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            active_reg     <= active_next;
            tick_reg       <= tick_next;
            pend_valid_reg <= pend_valid_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_handle_reg <= pend_handle_next;
        if (push)
        begin
            status_reg  <= pend_status_reg;
            handle_reg  <= pend_handle_reg;
            last_reg    <= push_last;
            elapsed_reg <= tick_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[idx_reg];
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign handle        = handle_reg;
    assign last          = last_reg;
    assign elapsed_ticks = elapsed_reg;

endmodule

// ===== hdl/mtcq_checker.sv =====
// Port-level checks for the multi-timer callout queue, bound to the top level.
module mtcq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [mtcq_pkg::KIND_W-1:0]   kind,
    input logic [mtcq_pkg::PERIOD_W-1:0] period_ms,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [mtcq_pkg::STATUS_W-1:0] status,
    input logic [mtcq_pkg::HANDLE_W-1:0] handle,
    input logic                          last,
    input logic [mtcq_pkg::TICK_W-1:0]   elapsed_ticks
);

    // A start or cancel transaction always keeps the block busy in the cycle after it is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall &&
         (kind == mtcq_pkg::KIND_START || kind == mtcq_pkg::KIND_CANCEL)) |=> in_stall)
    else $error("start or cancel did not occupy the block");

    // A start or cancel produces exactly one result, so it is always the last one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == mtcq_pkg::STATUS_OK || status == mtcq_pkg::STATUS_FAIL))
        |-> last)
    else $error("ok or fail result without last");

    // A zero-period start is still answered, so it occupies the block like any other start.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && kind == mtcq_pkg::KIND_START && period_ms == '0)
        |=> in_stall)
    else $error("zero-period start was not processed");

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
        (out_valid && $stable(status) && $stable(handle) && $stable(last) &&
         $stable(elapsed_ticks)))
    else $error("stalled result changed");

endmodule

bind multi_timer_callout_queue_core mtcq_checker u_mtcq_checker (.*);
